// ===== rtl/lsot_pkg.sv =====
// ----------------------------------------------------------------------------
// lsot_pkg: shared types and constants for the line start offset table
// Holds the operation codes and the newline character code.
// ----------------------------------------------------------------------------
package lsot_pkg;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_BYTE   = 3'd1,
		OP_FIND   = 3'd2,
		OP_LSTART = 3'd3,
		OP_LLEN   = 3'd4,
		OP_INS    = 3'd5,
		OP_DEL    = 3'd6,
		OP_NOP    = 3'd7
	} op_t;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

endpackage

// ===== rtl/line_start_offset_table.sv =====
// ----------------------------------------------------------------------------
// line_start_offset_table: sorted table of line-start offsets
// One request in, one response out; the table sits in one synchronous RAM.
// ----------------------------------------------------------------------------
// Each transaction is worked one at a time. Find runs a binary search over
// the table, each step reading one entry and then comparing it. Insert and
// delete also search first and then shift the entries above the hit line
// through the RAM, reading each entry and then writing it one place up or
// down. A response waits in an output register; the next request is taken
// once the response has left. Entry zero is cleared in the first cycle after
// reset while the input is held off; the other entries stay undefined until
// written.
module line_start_offset_table
	import lsot_pkg::*;
#(
	parameter int MAX_LINES   = 1024,
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[2:0], data_byte[10:3], byte_offset[34:11], line_number[44:35],
	// content_length[68:45], zero fill
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// found_line[9:0], start_offset[33:10], line_length[57:34],
	// lines_in_table[68:58], status[69], zero fill
	output logic [71:0] m_tdata
);

	localparam int AW = $clog2(MAX_LINES);
	localparam int CW = $clog2(MAX_LINES + 1);
	localparam int OW = OFFSET_BITS;
	localparam logic [OW-1:0] OTOP = {OW{1'b1}};

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DISP  = 10'b0000000010,
		ST_SRD   = 10'b0000000100,
		ST_SCMP  = 10'b0000001000,
		ST_QRD   = 10'b0000010000,
		ST_QA    = 10'b0000100000,
		ST_QB    = 10'b0001000000,
		ST_MRD   = 10'b0010000000,
		ST_MWR   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic   clr_q;

	// request registers
	op_t         op_q;
	logic [7:0]  byte_q;
	logic [OW-1:0] off_q;
	logic [9:0]  line_q;
	logic [23:0] clen_q;

	logic [CW-1:0] total_q;
	logic [23:0]   pos_q;

	logic [AW-1:0] lo_q, hi_q, mid_q, idx_q;
	logic [OW-1:0] a_q;

	// result
	logic [9:0]  found_q;
	logic [23:0] start_q, len_q;
	logic        status_q;

	// memory
	logic [OW-1:0] mem [MAX_LINES];
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [OW-1:0] wdata, rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// offsets from the bus, clamped to the table width
	logic [23:0] in_off;
	logic [OW-1:0] in_off_c;
	assign in_off = s_tdata[34:11];
	always_comb begin
		if (OW >= 24)
			in_off_c = OW'(in_off);
		else if ((in_off >> OW) != 24'd0)
			in_off_c = OTOP;
		else
			in_off_c = OW'(in_off);
	end

	function automatic logic [OW-1:0] inc_sat(input logic [OW-1:0] v);
		return (v == OTOP) ? v : v + 1'b1;
	endfunction

	function automatic logic [OW-1:0] dec_sat(input logic [OW-1:0] v);
		return (v == '0) ? v : v - 1'b1;
	endfunction

	logic [AW-1:0] last_idx;
	logic          full;
	logic [AW-1:0] line_c;
	logic [AW-1:0] mid_c;
	logic [AW:0]   diff;
	assign last_idx = AW'(total_q - 1'b1);
	assign full     = (total_q >= CW'(MAX_LINES));
	assign diff     = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign mid_c    = lo_q + AW'(diff >> 1);

	logic [31:0] pos_inc;
	assign pos_inc = {8'd0, pos_q} + 32'd1;

	// offset after a newline, saturated at the top
	logic [OW-1:0] pos_off;
	always_comb begin
		if (pos_inc > 32'(OTOP))
			pos_off = OTOP;
		else
			pos_off = OW'(pos_inc);
	end

	// line clamp for the start query
	logic line_beyond;
	assign line_beyond = ({{(CW > 10 ? CW-10 : 0){1'b0}}, line_q} >= total_q);
	assign line_c = line_beyond ? last_idx : AW'(line_q);

	// length differences, sign in the top bit
	logic [OW:0] lsub_last, lsub_next;
	assign lsub_last = {1'b0, OW'(clen_q)} - {1'b0, rdata_q};
	assign lsub_next = {1'b0, rdata_q} - {1'b0, a_q} - 1'b1;

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata_q;
		raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (clr_q) begin
					we    = 1'b1;
					waddr = '0;
					wdata = '0;
				end
			end
			ST_SRD:  raddr = mid_c;
			ST_QRD:  raddr = (op_q == OP_LSTART) ? line_c : AW'(line_q);
			ST_QA:   raddr = AW'(line_q) + 1'b1;
			ST_MRD:  raddr = (op_q == OP_INS) ? idx_q : idx_q + 1'b1;
			ST_MWR: begin
				we    = 1'b1;
				waddr = (op_q == OP_INS) ? idx_q + 1'b1 : idx_q;
				wdata = (op_q == OP_INS) ? inc_sat(rdata_q) : dec_sat(rdata_q);
			end
			ST_DISP: begin
				if (op_q == OP_START) begin
					we    = 1'b1;
					waddr = '0;
					wdata = '0;
				end else if (op_q == OP_BYTE && byte_q == NEWLINE_CODE && !full) begin
					we    = 1'b1;
					waddr = AW'(total_q);
					wdata = pos_off;
				end
			end
			ST_SCMP: begin
				// insert writes its new entry once the shift is done
				if (op_q == OP_INS && lo_q == hi_q && idx_q == lo_q + 1'b1 &&
					mid_q == lo_q) begin
					we    = 1'b1;
					waddr = idx_q;
					wdata = inc_sat(off_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			clr_q    <= 1'b1;
			total_q  <= CW'(1);
			pos_q    <= '0;
		end else begin
			clr_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready)
						state_q <= ST_DISP;
				end
				ST_DISP: begin
					unique case (op_q)
						OP_START: begin
							total_q <= CW'(1);
							pos_q   <= '0;
							state_q <= ST_OUT;
						end
						OP_BYTE: begin
							if (byte_q == NEWLINE_CODE && !full)
								total_q <= total_q + 1'b1;
							if (pos_q != 24'hFFFFFF)
								pos_q <= pos_q + 1'b1;
							state_q <= ST_OUT;
						end
						OP_FIND, OP_INS, OP_DEL: begin
							if ((op_q == OP_INS && full) ||
								(op_q == OP_DEL && total_q <= CW'(1))) begin
								status_q <= 1'b1;
								state_q  <= ST_OUT;
							end else if (lo_q == hi_q) begin
								mid_q   <= '1;
								state_q <= ST_SCMP;
							end else begin
								state_q <= ST_SRD;
							end
						end
						OP_LSTART, OP_LLEN: state_q <= ST_QRD;
						default:            state_q <= ST_OUT;
					endcase
				end
				ST_SRD: begin
					mid_q   <= mid_c;
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (lo_q != hi_q) begin
						if (rdata_q <= off_q)
							lo_q <= mid_q;
						else
							hi_q <= mid_q - 1'b1;
						// next step, or search done
						if ((rdata_q <= off_q && mid_q == hi_q) ||
							(!(rdata_q <= off_q) && mid_q - 1'b1 == lo_q)) begin
							mid_q   <= '1;
							state_q <= ST_SCMP;
						end else begin
							state_q <= ST_SRD;
						end
					end else begin
						// search result in lo_q
						found_q <= 10'(lo_q);
						unique case (op_q)
							OP_INS: begin
								if (mid_q == lo_q) begin
									total_q <= total_q + 1'b1;
									state_q <= ST_OUT;
								end else if (idx_q == lo_q + 1'b1 ||
									AW'(total_q) == lo_q + 1'b1) begin
									idx_q   <= lo_q + 1'b1;
									mid_q   <= lo_q;
									state_q <= ST_SCMP;
								end else begin
									idx_q   <= AW'(total_q) - 1'b1;
									state_q <= ST_MRD;
								end
							end
							OP_DEL: begin
								if (lo_q == last_idx) begin
									status_q <= 1'b1;
									state_q  <= ST_OUT;
								end else if (lo_q + 1'b1 == last_idx) begin
									// merge into the last line, nothing to shift
									total_q <= total_q - 1'b1;
									state_q <= ST_OUT;
								end else begin
									idx_q   <= lo_q + 1'b1;
									state_q <= ST_MRD;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MRD: state_q <= ST_MWR;
				ST_MWR: begin
					if (op_q == OP_INS) begin
						if (idx_q == lo_q + 1'b1) begin
							idx_q   <= lo_q + 1'b1;
							mid_q   <= lo_q;
							state_q <= ST_SCMP;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= ST_MRD;
						end
					end else begin
						if (idx_q + 1'b1 == last_idx) begin
							total_q <= total_q - 1'b1;
							state_q <= ST_OUT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_MRD;
						end
					end
				end
				ST_QRD: state_q <= ST_QA;
				ST_QA: begin
					a_q <= rdata_q;
					if (op_q == OP_LSTART) begin
						start_q <= 24'(rdata_q);
						state_q <= ST_OUT;
					end else if (line_beyond) begin
						state_q <= ST_OUT;
					end else if (AW'(line_q) == last_idx) begin
						if ((OW < 24 && (clen_q >> OW) != 24'd0))
							len_q <= 24'({1'b0, OTOP} - {1'b0, rdata_q}) +
								(clen_q - 24'(OTOP));
						else if (!lsub_last[OW] && lsub_last != '0)
							len_q <= 24'(lsub_last[OW-1:0]);
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_QB;
					end
				end
				ST_QB: begin
					if (rdata_q > a_q && !lsub_next[OW])
						len_q <= 24'(lsub_next[OW-1:0]);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (s_tvalid && s_tready) begin
				op_q     <= op_t'(s_tdata[2:0]);
				byte_q   <= s_tdata[10:3];
				off_q    <= in_off_c;
				line_q   <= s_tdata[44:35];
				clen_q   <= s_tdata[68:45];
				lo_q     <= '0;
				hi_q     <= last_idx;
				idx_q    <= '0;
				mid_q    <= '1;
				found_q  <= '0;
				start_q  <= '0;
				len_q    <= '0;
				status_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE) && !clr_q;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {2'b00, status_q, 11'(total_q), len_q, start_q, found_q};

	ap_total_min: assert property (@(posedge clk) disable iff (!arst_n)
		total_q != '0) else $error("line count dropped to zero");
	ap_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_LINES)) else $error("line count above table size");
	ap_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT || (state_q == ST_IDLE && !clr_q)) |-> !we)
		else $error("table written while not busy");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("response changed while stalled");

endmodule

// ===== tb/sv/line_start_offset_table_checker.sv =====
// ----------------------------------------------------------------------------
// line_start_offset_table_checker: response checker for the line offset table
// Watches both stream channels, keeps its own copy of the offset table,
// predicts the response of every accepted request and compares field by field.
// ----------------------------------------------------------------------------
module line_start_offset_table_checker
	import lsot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	output int          mismatches,
	output int          outstanding
);

	localparam int  TABLE_DEPTH = 1024;
	localparam longint OFF_TOP  = 64'hFF_FFFF;

	typedef struct packed {
		logic [9:0]  found_line;
		logic [23:0] start_offset;
		logic [23:0] line_length;
		logic [10:0] lines_in_table;
		logic        status;
	} response_t;

	longint    line_starts [TABLE_DEPTH];
	int        line_total;
	longint    build_pos;
	response_t expected_responses [$];

	assign outstanding = expected_responses.size();

	function automatic int search_line(longint off);
		int lo, hi, mid;
		lo = 0;
		hi = line_total - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (line_starts[mid] <= off) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint bump_up(longint v);
		return (v >= OFF_TOP) ? OFF_TOP : v + 1;
	endfunction

	function automatic longint bump_down(longint v);
		return (v == 0) ? 0 : v - 1;
	endfunction

	// Apply one request to the table copy and return the response it yields.
	function automatic response_t apply_request(logic [71:0] req);
		op_t       op;
		logic [7:0] ch;
		longint    off, clen, a, b;
		int        ln, i;
		response_t r;
		op   = op_t'(req[2:0]);
		ch   = req[10:3];
		off  = longint'(req[34:11]);
		ln   = int'(req[44:35]);
		clen = longint'(req[68:45]);
		r    = '0;
		case (op)
			OP_START: begin
				line_starts[0] = 0;
				line_total = 1;
				build_pos = 0;
			end
			OP_BYTE: begin
				if (ch == NEWLINE_CODE && line_total < TABLE_DEPTH) begin
					line_starts[line_total] = (build_pos + 1 > OFF_TOP) ? OFF_TOP :
						build_pos + 1;
					line_total++;
				end
				if (build_pos < OFF_TOP) build_pos++;
			end
			OP_FIND: r.found_line = 10'(search_line(off));
			OP_LSTART: begin
				if (ln >= line_total) ln = line_total - 1;
				r.start_offset = 24'(line_starts[ln]);
			end
			OP_LLEN: begin
				if (ln < line_total) begin
					if (ln == line_total - 1) begin
						r.line_length = (clen > line_starts[ln]) ?
							24'(clen - line_starts[ln]) : 24'd0;
					end else begin
						a = line_starts[ln];
						b = line_starts[ln + 1];
						r.line_length = (b > a + 1) ? 24'(b - a - 1) : 24'd0;
					end
				end
			end
			OP_INS: begin
				if (line_total >= TABLE_DEPTH) begin
					r.status = 1'b1;
				end else begin
					ln = search_line(off);
					r.found_line = 10'(ln);
					for (i = line_total; i > ln + 1; i--)
						line_starts[i] = bump_up(line_starts[i - 1]);
					line_starts[ln + 1] = bump_up(off);
					line_total++;
				end
			end
			OP_DEL: begin
				if (line_total <= 1) begin
					r.status = 1'b1;
				end else begin
					ln = search_line(off);
					r.found_line = 10'(ln);
					if (ln + 1 >= line_total) begin
						r.status = 1'b1;
					end else begin
						for (i = ln + 1; i + 1 < line_total; i++)
							line_starts[i] = bump_down(line_starts[i + 1]);
						line_total--;
					end
				end
			end
			default: ;
		endcase
		r.lines_in_table = 11'(line_total);
		return r;
	endfunction

	task automatic report(string field, longint exp_v, longint act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
	endtask

	initial begin
		mismatches = 0;
		line_starts[0] = 0;
		line_total = 1;
		build_pos = 0;
	end

	always @(posedge clk) begin
		response_t exp_r;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_responses.push_back(apply_request(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_responses.size() == 0) begin
					report("unexpected response, lines_in_table", -1,
						longint'(m_tdata[68:58]));
				end else begin
					exp_r = expected_responses.pop_front();
					if (m_tdata[9:0] !== exp_r.found_line)
						report("found_line", longint'(exp_r.found_line),
							longint'(m_tdata[9:0]));
					if (m_tdata[33:10] !== exp_r.start_offset)
						report("start_offset", longint'(exp_r.start_offset),
							longint'(m_tdata[33:10]));
					if (m_tdata[57:34] !== exp_r.line_length)
						report("line_length", longint'(exp_r.line_length),
							longint'(m_tdata[57:34]));
					if (m_tdata[68:58] !== exp_r.lines_in_table)
						report("lines_in_table", longint'(exp_r.lines_in_table),
							longint'(m_tdata[68:58]));
					if (m_tdata[69] !== exp_r.status)
						report("status", longint'(exp_r.status), longint'(m_tdata[69]));
				end
			end
		end
	end

endmodule

// ===== tb/sv/line_start_offset_table_test.sv =====
// ----------------------------------------------------------------------------
// line_start_offset_table_test: testbench top for the line offset table
// Drives directed and random build, query and edit requests with random
// idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module line_start_offset_table_test;
	import lsot_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	bit          burst_mode = 1'b0;
	bit          hold_request = 1'b0;
	bit          hold_done = 1'b0;
	int          text_span = 0;

	always #5 clk = ~clk;

	line_start_offset_table i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	line_start_offset_table_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Count cycles in which no transaction moves on either channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(op_t op, logic [7:0] ch, logic [23:0] off,
			logic [9:0] ln, logic [23:0] clen);
		int gap;
		gap = burst_mode ? 0 : int'($urandom_range(0, 9));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b0, clen, ln, off, ch, op};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [23:0] pick_offset();
		if ($urandom_range(0, 3) != 0) return 24'($urandom_range(0, text_span + 3));
		return 24'($urandom());
	endfunction

	function automatic logic [9:0] pick_line();
		if ($urandom_range(0, 3) != 0) return 10'($urandom_range(0, 40));
		return 10'($urandom());
	endfunction

	// Response side: random stall per transaction, one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = 400;
			end else begin
				stall = burst_mode ? 0 : int'($urandom_range(0, 9));
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int n, k;
		logic [7:0] ch;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: one empty line
		send_request(OP_FIND, 8'h00, 24'h000000, 10'd0, 24'h000000);
		send_request(OP_LSTART, 8'h00, 24'h000000, 10'd0, 24'h000000);
		send_request(OP_LLEN, 8'h00, 24'h000000, 10'd0, 24'h000000);
		send_request(OP_DEL, 8'h00, 24'h000000, 10'd0, 24'h000000);
		send_request(OP_NOP, 8'hFF, 24'hFFFFFF, 10'h3FF, 24'hFFFFFF);
		// short build with adjacent newlines
		send_request(OP_START, 8'h00, 24'h0, 10'd0, 24'h0);
		send_request(OP_BYTE, 8'h61, 24'h0, 10'd0, 24'h0);
		send_request(OP_BYTE, NEWLINE_CODE, 24'h0, 10'd0, 24'h0);
		send_request(OP_BYTE, NEWLINE_CODE, 24'h0, 10'd0, 24'h0);
		send_request(OP_BYTE, 8'hFF, 24'h0, 10'd0, 24'h0);
		send_request(OP_BYTE, NEWLINE_CODE, 24'h0, 10'd0, 24'h0);
		send_request(OP_FIND, 8'h00, 24'hFFFFFF, 10'd0, 24'h0);
		send_request(OP_FIND, 8'h00, 24'd2, 10'd0, 24'h0);
		send_request(OP_LSTART, 8'h00, 24'h0, 10'h3FF, 24'h0);
		send_request(OP_LLEN, 8'h00, 24'h0, 10'h3FF, 24'h0);
		send_request(OP_LLEN, 8'h00, 24'h0, 10'd3, 24'h0);
		send_request(OP_LLEN, 8'h00, 24'h0, 10'd3, 24'hFFFFFF);
		send_request(OP_LLEN, 8'h00, 24'h0, 10'd1, 24'h0);
		send_request(OP_INS, 8'h00, 24'hFFFFFF, 10'd0, 24'h0);
		send_request(OP_INS, 8'h00, 24'hFFFFFE, 10'd0, 24'h0);
		send_request(OP_DEL, 8'h00, 24'hFFFFFF, 10'd0, 24'h0);
		send_request(OP_DEL, 8'h00, 24'd1, 10'd0, 24'h0);
		send_request(OP_INS, 8'h00, 24'd0, 10'd0, 24'h0);

		// random part: short builds followed by queries and edits
		n = 0;
		text_span = 0;
		while (n < 560) begin
			if (n >= 280 && !hold_done) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 7) == 0) begin
				burst_mode = ($urandom_range(0, 3) == 0);
				send_request(OP_START, 8'($urandom()), 24'($urandom()), 10'($urandom()),
					24'($urandom()));
				text_span = int'($urandom_range(1, 30));
				for (k = 0; k < text_span; k++) begin
					ch = ($urandom_range(0, 3) == 0) ? NEWLINE_CODE : 8'($urandom());
					send_request(OP_BYTE, ch, 24'($urandom()), 10'($urandom()),
						24'($urandom()));
				end
				n += text_span + 1;
			end else begin
				case ($urandom_range(0, 11))
					0, 1:    send_request(OP_FIND, 8'($urandom()), pick_offset(),
							10'($urandom()), 24'($urandom()));
					2, 3:    send_request(OP_LSTART, 8'($urandom()), 24'($urandom()),
							pick_line(), 24'($urandom()));
					4, 5:    send_request(OP_LLEN, 8'($urandom()), 24'($urandom()),
							pick_line(),
							($urandom_range(0, 2) == 0) ? 24'($urandom()) :
							24'($urandom_range(0, text_span + 2)));
					6, 7: begin
						send_request(OP_INS, 8'($urandom()), pick_offset(),
							10'($urandom()), 24'($urandom()));
						text_span++;
					end
					8, 9:    send_request(OP_DEL, 8'($urandom()), pick_offset(),
							10'($urandom()), 24'($urandom()));
					10:      send_request(OP_BYTE, 8'($urandom()), 24'($urandom()),
							10'($urandom()), 24'($urandom()));
					default: send_request(OP_NOP, 8'($urandom()), 24'($urandom()),
							10'($urandom()), 24'($urandom()));
				endcase
				n++;
			end
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== line_start_offset_table.f =====
rtl/lsot_pkg.sv
rtl/line_start_offset_table.sv
tb/sv/line_start_offset_table_checker.sv
tb/sv/line_start_offset_table_test.sv
